### hdl/ps2mpt_pkg.sv
// shared types, constants and helpers of the ps/2 mouse packet cursor tracker
package ps2mpt_pkg;

	localparam int EVENT_DEPTH = 64;
	localparam int COORD_BITS  = 12;
	localparam int RING_AW     = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int COORD_LIM   = 1 << COORD_BITS;
	localparam int EFF_W       = COORD_BITS + 1;
	localparam int VAL_W       = COORD_BITS + 2;

	localparam int ID_W   = 8;
	localparam int SCR_W  = 13;
	localparam int CFG_W  = 13;
	localparam int CIDX_W = 2;
	localparam int OP_W   = 2;
	localparam int CNT_W  = 3;

	// opcodes of an input item
	localparam logic [OP_W-1:0] OP_BYTE     = 2'd0;
	localparam logic [OP_W-1:0] OP_READ     = 2'd1;
	localparam logic [OP_W-1:0] OP_RECENTRE = 2'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_DEVICE_ID     = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

	localparam logic [ID_W-1:0]  DEVICE_ID_RST     = 8'd0;
	localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

	localparam logic [ID_W-1:0] ID_WHEEL   = 8'h03;
	localparam logic [ID_W-1:0] ID_FIVEBTN = 8'h04;
	localparam logic [ID_W-1:0] ID_EXT     = 8'h81;

	localparam logic [CNT_W-1:0] LEN_STD  = 3'd3;
	localparam logic [CNT_W-1:0] LEN_FOUR = 3'd4;
	localparam logic [CNT_W-1:0] LEN_FIVE = 3'd5;

	localparam int QUEUE_DEPTH = 3;
	localparam int QP_W        = 2;

	typedef struct packed {
		logic [7:0]            status;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} ring_entry_t;

	typedef struct packed {
		logic               wr_en;
		logic [RING_AW-1:0] wr_addr;
		ring_entry_t        wr_data;
		logic               rd_en;
		logic [RING_AW-1:0] rd_addr;
	} ring_req_t;

	typedef struct packed {
		logic                  event_valid;
		logic [7:0]            event_status;
		logic [COORD_BITS-1:0] event_x;
		logic [COORD_BITS-1:0] event_y;
		logic [COORD_BITS-1:0] cursor_x;
		logic [COORD_BITS-1:0] cursor_y;
		logic                  packet_done;
		logic                  packet_overflow;
	} result_t;

	// a size of zero counts as one, anything past the coordinate range is clipped
	function automatic logic [EFF_W-1:0] eff_size(input logic [SCR_W-1:0] s);
		logic [EFF_W-1:0] r;
		if (s == '0) begin
			r = EFF_W'(1);
		end else if (32'(s) > COORD_LIM) begin
			r = EFF_W'(COORD_LIM);
		end else begin
			r = EFF_W'(s);
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] packet_len(input logic [ID_W-1:0] id);
		logic [CNT_W-1:0] r;
		if (id == ID_WHEEL || id == ID_FIVEBTN) begin
			r = LEN_FOUR;
		end else if (id == ID_EXT) begin
			r = LEN_FIVE;
		end else begin
			r = LEN_STD;
		end
		return r;
	endfunction

	function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
		logic [RING_AW-1:0] r;
		if (32'(p) == EVENT_DEPTH - 1) begin
			r = '0;
		end else begin
			r = p + RING_AW'(1);
		end
		return r;
	endfunction

endpackage

### hdl/ps2mpt_ifs.sv
// valid/ready channel interfaces for mouse items and results
interface ps2mpt_in_if import ps2mpt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] opcode;
	logic [7:0]      data_byte;
	logic            requester_on_top;

	modport source(output valid, output opcode, output data_byte, output requester_on_top,
		input ready);
	modport sink(input valid, input opcode, input data_byte, input requester_on_top,
		output ready);
endinterface

interface ps2mpt_out_if import ps2mpt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  event_valid;
	logic [7:0]            event_status;
	logic [COORD_BITS-1:0] event_x;
	logic [COORD_BITS-1:0] event_y;
	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic                  packet_done;
	logic                  packet_overflow;

	modport source(output valid, output event_valid, output event_status, output event_x,
		output event_y, output cursor_x, output cursor_y, output packet_done,
		output packet_overflow, input ready);
	modport sink(input valid, input event_valid, input event_status, input event_x,
		input event_y, input cursor_x, input cursor_y, input packet_done,
		input packet_overflow, output ready);
endinterface

### hdl/ps2mpt_ring.sv
// event ring storage: one write port, one registered read port
module ps2mpt_ring import ps2mpt_pkg::*; (
	input  logic        clk,
	input  ring_req_t   req,
	output ring_entry_t rd_data
);

	ring_entry_t mem [EVENT_DEPTH];
	ring_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/ps2mpt_axis.sv
// one cursor axis: add the movement and clamp to the screen
module ps2mpt_axis import ps2mpt_pkg::*; (
	input  logic [COORD_BITS-1:0] pos,
	input  logic signed [9:0]     delta,
	input  logic [EFF_W-1:0]      lim,
	output logic [COORD_BITS-1:0] new_pos
);

	logic signed [VAL_W-1:0] d_ext;
	logic signed [VAL_W-1:0] v;
	logic signed [VAL_W-1:0] lim_s;
	logic [EFF_W-1:0]        lim_m1;

	assign d_ext  = VAL_W'(delta);
	assign v      = signed'({2'b00, pos}) + d_ext;
	assign lim_s  = signed'({1'b0, lim});
	assign lim_m1 = lim - EFF_W'(1);

	always_comb begin
		if (v >= lim_s) begin
			new_pos = lim_m1[COORD_BITS-1:0];
		end else if (v < 0) begin
			new_pos = '0;
		end else begin
			new_pos = v[COORD_BITS-1:0];
		end
	end

endmodule

### hdl/ps2mpt_outq.sv
// three-entry result queue between the ring read stage and the output channel
module ps2mpt_outq import ps2mpt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    not_empty,
	output result_t head_data,
	output logic [QP_W-1:0] count
);

	result_t         q_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QP_W-1:0] count_q;
	logic            do_pop;

	function automatic logic [QP_W-1:0] qp_inc(input logic [QP_W-1:0] p);
		logic [QP_W-1:0] r;
		if (32'(p) == QUEUE_DEPTH - 1) begin
			r = '0;
		end else begin
			r = p + QP_W'(1);
		end
		return r;
	endfunction

	assign not_empty = (count_q != '0);
	assign head_data = q_q[rd_ptr_q];
	assign count     = count_q;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= qp_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= qp_inc(rd_ptr_q);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QP_W'(1);
				2'b01:   count_q <= count_q - QP_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/ps2_mouse_packet_cursor_tracker.sv
// top level: packet assembly, cursor tracking and the event ring
//
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    opcode, data_byte, requester_on_top
//  out_ch    out   valid / ready    event fields, cursor, packet_done, packet_overflow
//  cfg       in    cfg_wr_en        cfg_index, cfg_data
//
// one item per cycle while in_ch.ready is high; a result is registered at the ring's
// registered read port in stage 1 and then in the result queue before it reaches out_ch
// reset clears cursor, packet count, ring pointers and the queue; ring contents
// stay undefined until written
// up to three results may be in flight; input is held off only when all are waiting
module ps2_mouse_packet_cursor_tracker import ps2mpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ps2mpt_in_if.sink           in_ch,
	ps2mpt_out_if.source        out_ch,
	input  logic                cfg_wr_en,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	logic [ID_W-1:0]       device_id_q;
	logic [SCR_W-1:0]      screen_width_q;
	logic [SCR_W-1:0]      screen_height_q;
	logic [7:0]            pkt_q [3];
	logic [CNT_W-1:0]      byte_count_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;
	logic [RING_AW-1:0]    head_q;
	logic [RING_AW-1:0]    tail_q;

	logic                  valid_s1;
	logic                  pop_s1;
	result_t               res_s1;

	logic                  accept;
	logic                  is_byte;
	logic                  is_read;
	logic                  is_recentre;
	logic [CNT_W-1:0]      count_inc;
	logic                  complete;
	logic [7:0]            st;
	logic [7:0]            b1;
	logic [7:0]            b2;
	logic signed [8:0]     raw_x;
	logic signed [8:0]     raw_y;
	logic signed [9:0]     dx;
	logic signed [9:0]     dy;
	logic                  ovf;
	logic                  moves;
	logic                  push_ev;
	logic                  pop_ev;
	logic [EFF_W-1:0]      eff_w;
	logic [EFF_W-1:0]      eff_h;
	logic [COORD_BITS-1:0] mx;
	logic [COORD_BITS-1:0] my;
	logic [COORD_BITS-1:0] nx;
	logic [COORD_BITS-1:0] ny;
	ring_req_t             ring_req;
	ring_entry_t           ring_rd;
	result_t               res_in;
	result_t               q_head;
	logic                  q_not_empty;
	logic [QP_W-1:0]       q_count;

	assign accept      = in_ch.valid && in_ch.ready;
	assign is_byte     = (in_ch.opcode == OP_BYTE);
	assign is_read     = (in_ch.opcode == OP_READ);
	assign is_recentre = (in_ch.opcode == OP_RECENTRE);

	// the newest byte stands in for the stored one at its own position
	assign count_inc = byte_count_q + CNT_W'(1);
	assign complete  = is_byte && (count_inc >= packet_len(device_id_q));
	assign st        = (byte_count_q == CNT_W'(0)) ? in_ch.data_byte : pkt_q[0];
	assign b1        = (byte_count_q == CNT_W'(1)) ? in_ch.data_byte : pkt_q[1];
	assign b2        = (byte_count_q == CNT_W'(2)) ? in_ch.data_byte : pkt_q[2];

	assign raw_x = signed'({st[4], b1});
	assign raw_y = signed'({st[5], b2});
	assign dx    = 10'(raw_x);
	assign dy    = -(10'(raw_y));
	assign ovf   = st[7] || st[6];
	assign moves = (raw_x != '0) || (raw_y != '0);

	assign eff_w = eff_size(screen_width_q);
	assign eff_h = eff_size(screen_height_q);

	ps2mpt_axis u_axis_x (
		.pos     (pos_x_q),
		.delta   (dx),
		.lim     (eff_w),
		.new_pos (mx)
	);

	ps2mpt_axis u_axis_y (
		.pos     (pos_y_q),
		.delta   (dy),
		.lim     (eff_h),
		.new_pos (my)
	);

	always_comb begin
		nx = pos_x_q;
		ny = pos_y_q;
		if (complete && !ovf && moves) begin
			nx = mx;
			ny = my;
		end else if (is_recentre) begin
			nx = COORD_BITS'(eff_w >> 1);
			ny = COORD_BITS'(eff_h >> 1);
		end
	end

	assign push_ev = accept && complete && !ovf && (st[2:0] != 3'b000);
	assign pop_ev  = accept && is_read && in_ch.requester_on_top && (head_q != tail_q);

	always_comb begin
		ring_req.wr_en          = push_ev;
		ring_req.wr_addr        = head_q;
		ring_req.wr_data.status = st;
		ring_req.wr_data.x      = nx;
		ring_req.wr_data.y      = ny;
		ring_req.rd_en          = pop_ev;
		ring_req.rd_addr        = tail_q;
	end

	ps2mpt_ring u_ring (
		.clk     (clk),
		.req     (ring_req),
		.rd_data (ring_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q     <= DEVICE_ID_RST;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEVICE_ID:     device_id_q     <= cfg_data[ID_W-1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[SCR_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[SCR_W-1:0];
				default:           device_id_q     <= device_id_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q[0]     <= '0;
			pkt_q[1]     <= '0;
			pkt_q[2]     <= '0;
			byte_count_q <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
		end else if (accept) begin
			if (is_byte) begin
				if (byte_count_q == CNT_W'(0)) pkt_q[0] <= in_ch.data_byte;
				if (byte_count_q == CNT_W'(1)) pkt_q[1] <= in_ch.data_byte;
				if (byte_count_q == CNT_W'(2)) pkt_q[2] <= in_ch.data_byte;
				byte_count_q <= complete ? CNT_W'(0) : count_inc;
			end
			pos_x_q <= nx;
			pos_y_q <= ny;
			if (push_ev) begin
				head_q <= ring_inc(head_q);
			end
			if (pop_ev) begin
				tail_q <= ring_inc(tail_q);
			end
		end
	end

	// stage 1 waits for the ring read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			pop_s1   <= pop_ev;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.event_valid     <= 1'b0;
			res_s1.event_status    <= '0;
			res_s1.event_x         <= '0;
			res_s1.event_y         <= '0;
			res_s1.cursor_x        <= nx;
			res_s1.cursor_y        <= ny;
			res_s1.packet_done     <= complete;
			res_s1.packet_overflow <= complete && ovf;
		end
	end

	always_comb begin
		res_in = res_s1;
		if (pop_s1) begin
			res_in.event_valid  = 1'b1;
			res_in.event_status = ring_rd.status;
			res_in.event_x      = ring_rd.x;
			res_in.event_y      = ring_rd.y;
		end
	end

	ps2mpt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res_in),
		.pop       (out_ch.ready),
		.not_empty (q_not_empty),
		.head_data (q_head),
		.count     (q_count)
	);

	// stage 1 always drains into the queue, so both count towards its room
	assign in_ch.ready = (32'(q_count) + 32'(valid_s1)) < QUEUE_DEPTH;

	assign out_ch.valid           = q_not_empty;
	assign out_ch.event_valid     = q_head.event_valid;
	assign out_ch.event_status    = q_head.event_status;
	assign out_ch.event_x         = q_head.event_x;
	assign out_ch.event_y         = q_head.event_y;
	assign out_ch.cursor_x        = q_head.cursor_x;
	assign out_ch.cursor_y        = q_head.cursor_y;
	assign out_ch.packet_done     = q_head.packet_done;
	assign out_ch.packet_overflow = q_head.packet_overflow;

endmodule

### tb/testbench.sv
// testbench for the ps/2 mouse packet cursor tracker: directed table, random phases, predictor
`timescale 1ns / 1ps

module testbench;
	import ps2mpt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HALF_PERIOD = 2;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_LIMIT = 20000;
	localparam int PHASE_ITEMS = 40;
	localparam int OVERRUN_EVENTS = 68;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [7:0]      b;
		logic            top;
		logic            lit;
		result_t         res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ps2mpt_in_if in_ch ();
	ps2mpt_out_if out_ch ();

	ps2_mouse_packet_cursor_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// tracker mirror
	logic [7:0]            pkt_buf [0:2];
	logic [CNT_W-1:0]      pkt_count;
	logic [COORD_BITS-1:0] cur_x;
	logic [COORD_BITS-1:0] cur_y;
	ring_entry_t           ev_store [EVENT_DEPTH];
	logic [RING_AW-1:0]    wr_ptr;
	logic [RING_AW-1:0]    rd_ptr;
	logic [ID_W-1:0]       dev_id_m;
	logic [SCR_W-1:0]      width_m;
	logic [SCR_W-1:0]      height_m;

	result_t expected_results[$];
	int err_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit gap_free = 1'b0;

	function automatic int frame_len(input logic [ID_W-1:0] id);
		case (id)
			ID_WHEEL, ID_FIVEBTN: return 4;
			ID_EXT: return 5;
			default: return 3;
		endcase
	endfunction

	function automatic int clip_size(input logic [SCR_W-1:0] s);
		if (s == '0) return 1;
		if (int'(s) > COORD_LIM) return COORD_LIM;
		return int'(s);
	endfunction

	function automatic logic [COORD_BITS-1:0] step_axis(input logic [COORD_BITS-1:0] pos,
		input int delta, input int lim);
		int v;
		v = int'(pos) + delta;
		if (v >= lim) begin
			v = lim - 1;
		end else if (v < 0) begin
			v = 0;
		end
		return COORD_BITS'(v);
	endfunction

	function automatic result_t advance_tracker(input logic [OP_W-1:0] op, input logic [7:0] b,
		input logic top);
		result_t r;
		logic [7:0] st;
		int dx;
		int dy;
		r = '0;
		case (op)
			OP_BYTE: begin
				if (pkt_count < 3) pkt_buf[pkt_count] = b;
				pkt_count = pkt_count + 1'b1;
				if (int'(pkt_count) >= frame_len(dev_id_m)) begin
					st = pkt_buf[0];
					dx = int'(pkt_buf[1]) - (st[4] ? 256 : 0);
					// y axis points the other way on screen
					dy = (st[5] ? 256 : 0) - int'(pkt_buf[2]);
					pkt_count = '0;
					r.packet_done = 1'b1;
					if (st[7] || st[6]) begin
						r.packet_overflow = 1'b1;
					end else begin
						if (dx != 0 || dy != 0) begin
							cur_x = step_axis(cur_x, dx, clip_size(width_m));
							cur_y = step_axis(cur_y, dy, clip_size(height_m));
						end
						if (st[2:0] != 3'b000) begin
							ev_store[wr_ptr] = '{status: st, x: cur_x, y: cur_y};
							wr_ptr = RING_AW'((int'(wr_ptr) + 1) % EVENT_DEPTH);
						end
					end
				end
			end
			OP_READ: begin
				if (top && wr_ptr != rd_ptr) begin
					r.event_valid  = 1'b1;
					r.event_status = ev_store[rd_ptr].status;
					r.event_x      = ev_store[rd_ptr].x;
					r.event_y      = ev_store[rd_ptr].y;
					rd_ptr = RING_AW'((int'(rd_ptr) + 1) % EVENT_DEPTH);
				end
			end
			OP_RECENTRE: begin
				cur_x = COORD_BITS'(clip_size(width_m) / 2);
				cur_y = COORD_BITS'(clip_size(height_m) / 2);
			end
			default: begin
			end
		endcase
		r.cursor_x = cur_x;
		r.cursor_y = cur_y;
		return r;
	endfunction

	function automatic result_t fixed_result(input logic ev, input logic [7:0] st,
		input int ex, input int ey, input int cx, input int cy, input logic dn, input logic ov);
		result_t r;
		r.event_valid     = ev;
		r.event_status    = st;
		r.event_x         = COORD_BITS'(ex);
		r.event_y         = COORD_BITS'(ey);
		r.cursor_x        = COORD_BITS'(cx);
		r.cursor_y        = COORD_BITS'(cy);
		r.packet_done     = dn;
		r.packet_overflow = ov;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// small moves half the time so the cursor does not just sit on an edge
	function automatic logic [7:0] pick_delta(input logic sign);
		int r;
		if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
		r = $urandom_range(0, 4);
		return sign ? 8'(256 - r) : 8'(r);
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] b, input logic top);
		int gap;
		if (burst_left == 0) begin
			if (!gap_free) begin
				in_ch.valid <= 1'b0;
				gap = $urandom_range(1, 10);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid            <= 1'b1;
		in_ch.opcode           <= op;
		in_ch.data_byte        <= b;
		in_ch.requester_on_top <= top;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		expected_results.push_back(advance_tracker(op, b, top));
		burst_left--;
		items_sent++;
	endtask

	task automatic send_packet(input bit well_formed, input bit allow_ovf, input bit need_button);
		logic [7:0] st;
		logic [7:0] b;
		int len;
		st = 8'($urandom_range(0, 255));
		st[3] = ($urandom_range(0, 9) != 0);
		if (!allow_ovf || $urandom_range(0, 9) != 0) st[7:6] = 2'b00;
		if (need_button && st[2:0] == 3'b000) begin
			st[0] = 1'b1;
		end else if (!need_button && $urandom_range(0, 3) == 0) begin
			st[2:0] = 3'b000;
		end
		len = well_formed ? frame_len(dev_id_m) : $urandom_range(1, 6);
		send_item(OP_BYTE, st, 1'($urandom_range(0, 1)));
		for (int k = 1; k < len; k++) begin
			if (k == 1) begin
				b = pick_delta(st[4]);
			end else if (k == 2) begin
				b = pick_delta(st[5]);
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_item(OP_BYTE, b, 1'($urandom_range(0, 1)));
		end
	endtask

	// stop offering and let every outstanding result come back
	task automatic settle();
		int n;
		in_ch.valid <= 1'b0;
		n = 0;
		while (expected_results.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			err_count++;
			expected_results.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_screen(input logic [ID_W-1:0] dev, input logic [SCR_W-1:0] w,
		input logic [SCR_W-1:0] h);
		logic [CFG_W-ID_W-1:0] pad;
		pad = ($urandom_range(0, 1) == 0) ? '0 : (CFG_W-ID_W)'($urandom_range(0, 31));
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DEVICE_ID;
		cfg_data  <= {pad, dev};
		@(posedge clk);
		dev_id_m = dev;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		width_m = w;
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		height_m = h;
		cfg_wr_en <= 1'b0;
	endtask

	// result checking
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				err_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("event_valid", want.event_valid, out_ch.event_valid);
				check_field("event_status", want.event_status, out_ch.event_status);
				check_field("event_x", want.event_x, out_ch.event_x);
				check_field("event_y", want.event_y, out_ch.event_y);
				check_field("cursor_x", want.cursor_x, out_ch.cursor_x);
				check_field("cursor_y", want.cursor_y, out_ch.cursor_y);
				check_field("packet_done", want.packet_done, out_ch.packet_done);
				check_field("packet_overflow", want.packet_overflow, out_ch.packet_overflow);
			end
		end
	end

	// result side: stall modes that change now and then, plus long hold-offs
	int hold_left = 0;
	int next_hold = 120;
	int rx_count = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int tick = 0;

	always @(posedge clk) begin
		tick++;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) rx_count++;
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(16, 96);
		end else begin
			mode_left--;
		end
		if (hold_left == 0 && rx_count >= next_hold) begin
			hold_left = HOLD_CYCLES;
			next_hold += 240;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= (tick % 3 == 0);
				default: out_ch.ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	initial begin
		stim_row_t opening_rows[$];
		logic [ID_W-1:0] dev;
		logic [SCR_W-1:0] w;
		logic [SCR_W-1:0] h;
		int pk_share;
		int rd_share;
		int first_item;
		int r;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_BYTE;
		in_ch.data_byte = '0;
		in_ch.requester_on_top = 1'b0;
		out_ch.ready = 1'b0;

		for (int i = 0; i < 3; i++) pkt_buf[i] = '0;
		pkt_count = '0;
		cur_x = '0;
		cur_y = '0;
		wr_ptr = '0;
		rd_ptr = '0;
		dev_id_m = DEVICE_ID_RST;
		width_m = SCREEN_WIDTH_RST;
		height_m = SCREEN_HEIGHT_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused opcode and empty ring straight after reset
		opening_rows.push_back('{OP_UNUSED, 8'hA5, 1'b1, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 0, 0, 1'b0, 1'b0)});
		opening_rows.push_back('{OP_READ, 8'h00, 1'b1, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 0, 0, 1'b0, 1'b0)});
		opening_rows.push_back('{OP_RECENTRE, 8'h00, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 512, 384, 1'b0, 1'b0)});
		// button packet, x +255, y byte 1 gives a step up
		opening_rows.push_back('{OP_BYTE, 8'h09, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 512, 384, 1'b0, 1'b0)});
		opening_rows.push_back('{OP_BYTE, 8'hFF, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 512, 384, 1'b0, 1'b0)});
		opening_rows.push_back('{OP_BYTE, 8'h01, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 767, 383, 1'b1, 1'b0)});
		// refused read, then a read from the top window
		opening_rows.push_back('{OP_READ, 8'h00, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 767, 383, 1'b0, 1'b0)});
		opening_rows.push_back('{OP_READ, 8'h00, 1'b1, 1'b1,
			fixed_result(1'b1, 8'h09, 767, 383, 767, 383, 1'b0, 1'b0)});
		// both overflow bits, packet dropped
		opening_rows.push_back('{OP_BYTE, 8'hCF, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b1, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b1,
			fixed_result(1'b0, 8'h00, 0, 0, 767, 383, 1'b1, 1'b1)});
		// largest negative x and y bytes
		opening_rows.push_back('{OP_BYTE, 8'h38, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h18, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h7F, 1'b0, 1'b0, result_t'('0)});
		// x pushed below zero, clamps at the left edge
		opening_rows.push_back('{OP_BYTE, 8'h18, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		// no movement but all buttons: event still logged
		opening_rows.push_back('{OP_BYTE, 8'h0F, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_BYTE, 8'h00, 1'b0, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_READ, 8'hFF, 1'b1, 1'b0, result_t'('0)});
		opening_rows.push_back('{OP_READ, 8'h00, 1'b1, 1'b0, result_t'('0)});

		foreach (opening_rows[i]) begin
			send_item(opening_rows[i].op, opening_rows[i].b, opening_rows[i].top);
			if (opening_rows[i].lit) expected_results[expected_results.size() - 1] = opening_rows[i].res;
		end

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					dev = ID_EXT; w = 13'd1; h = 13'd1;
				end
				1: begin
					dev = ID_WHEEL; w = 13'd4096; h = 13'd4096;
				end
				2: begin
					dev = ID_FIVEBTN; w = 13'd0; h = 13'd8191;
				end
				3: begin
					dev = DEVICE_ID_RST; w = SCREEN_WIDTH_RST; h = SCREEN_HEIGHT_RST;
				end
				4: begin
					dev = 8'hFF; w = 13'd640; h = 13'd480;
				end
				default: begin
					case ($urandom_range(0, 5))
						0: dev = ID_WHEEL;
						1: dev = ID_FIVEBTN;
						2: dev = ID_EXT;
						3: dev = DEVICE_ID_RST;
						default: dev = 8'($urandom_range(0, 255));
					endcase
					w = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
						: 13'($urandom_range(1, 4096));
					h = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
						: 13'($urandom_range(1, 4096));
				end
			endcase
			settle();
			program_screen(dev, w, h);
			gap_free = ($urandom_range(0, 3) == 0);

			if (ph == 3) begin
				// line up on a packet start, then push more events than the ring holds
				while (pkt_count != '0) send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
				repeat (OVERRUN_EVENTS) send_packet(1'b1, 1'b0, 1'b1);
			end else begin
				pk_share = (ph == 4) ? 30 : 60;
				rd_share = (ph == 4) ? 55 : 25;
				first_item = items_sent;
				while (items_sent - first_item < PHASE_ITEMS) begin
					r = $urandom_range(0, 99);
					if (r < pk_share) begin
						send_packet($urandom_range(0, 9) != 0, 1'b1, 1'b0);
					end else if (r < pk_share + rd_share) begin
						send_item(OP_READ, 8'($urandom_range(0, 255)), $urandom_range(0, 5) != 0);
					end else if (r < pk_share + rd_share + 6) begin
						send_item(OP_RECENTRE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end else if (r < pk_share + rd_share + 10) begin
						send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end else begin
						send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					end
				end
			end
		end

		settle();
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("FAIL");
		$finish;
	end

endmodule
